// File: sv/tci_pkg.sv
// ----------------------------------------------------------------------------
// tci_pkg
// Shared constants, command codes and control structs for the trapezoid
// cubic integrator: controller, datapath and multiplier all draw on these.
// ----------------------------------------------------------------------------
package tci_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int IN_W          = 24;
	localparam int OUT_W         = 64;
	localparam int OUT_FRAC      = 24;
	localparam int ST_W          = 2;
	localparam int MUL_W         = 32;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD_STEP = 2'd1;
	localparam logic [ST_W-1:0] ST_SAT      = 2'd2;

	// datapath operations issued by the controller
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NOP      = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
	localparam logic [OP_W-1:0] OP_INIT     = 5'd2;
	localparam logic [OP_W-1:0] OP_ADV_FULL = 5'd3;
	localparam logic [OP_W-1:0] OP_ADV_PART = 5'd4;
	localparam logic [OP_W-1:0] OP_F1       = 5'd5;
	localparam logic [OP_W-1:0] OP_F2       = 5'd6;
	localparam logic [OP_W-1:0] OP_F3       = 5'd7;
	localparam logic [OP_W-1:0] OP_F4       = 5'd8;
	localparam logic [OP_W-1:0] OP_F5       = 5'd9;
	localparam logic [OP_W-1:0] OP_F6       = 5'd10;
	localparam logic [OP_W-1:0] OP_A1       = 5'd11;
	localparam logic [OP_W-1:0] OP_A2       = 5'd12;
	localparam logic [OP_W-1:0] OP_A3       = 5'd13;
	localparam logic [OP_W-1:0] OP_A4       = 5'd14;
	localparam logic [OP_W-1:0] OP_A5       = 5'd15;
	localparam logic [OP_W-1:0] OP_A6       = 5'd16;
	localparam logic [OP_W-1:0] OP_A7       = 5'd17;
	localparam logic [OP_W-1:0] OP_A8       = 5'd18;
	localparam logic [OP_W-1:0] OP_FIN      = 5'd19;
	localparam logic [OP_W-1:0] OP_BAD      = 5'd20;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} tci_cmd_t;

	typedef struct packed {
		logic bad_step;
		logic full_fits;
		logic part_left;
	} tci_stat_t;

endpackage

// File: sv/trapezoid_cubic_integrator_unit.sv
// ----------------------------------------------------------------------------
// trapezoid_cubic_integrator_unit
// Trapezoidal integration of x^3 - 3x^2 + 5 between two signed limits.
//
//   channel | direction | handshake           | beat
//   --------+-----------+---------------------+---------------------------------
//   in      | input     | in_valid / in_stall | left_limit, right_limit, step_width
//   out     | output    | out_valid/out_stall | integral, status
//
// Each trapezoid is an advance step, the cubic evaluation in states F1 to
// F6 and the area and sum in states A1 to A8, all sharing one 32x32
// multiplier. One beat is worked on at a time; the next is taken as soon
// as the result sits in the output register, stalled or not.
// Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module trapezoid_cubic_integrator_unit #(
	parameter int FRAC_BITS = tci_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [tci_pkg::IN_W-1:0]    left_limit,
	input  logic signed [tci_pkg::IN_W-1:0]    right_limit,
	input  logic signed [tci_pkg::IN_W-1:0]    step_width,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [tci_pkg::OUT_W-1:0]   integral,
	output logic [tci_pkg::ST_W-1:0]           status
);

	tci_pkg::tci_cmd_t  cmd;
	tci_pkg::tci_stat_t stat;

	tci_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	tci_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.stat        (stat),
		.left_limit  (left_limit),
		.right_limit (right_limit),
		.step_width  (step_width),
		.integral    (integral),
		.status      (status)
	);

endmodule

// File: sv/tci_mul.sv
// ----------------------------------------------------------------------------
// tci_mul
// Shared unsigned multiplier with a registered product, one product a cycle while en is high.
// ----------------------------------------------------------------------------
module tci_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tci_pkg::MUL_W-1:0]     a,
	input  logic [tci_pkg::MUL_W-1:0]     b,
	output logic [2*tci_pkg::MUL_W-1:0]   p_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

// File: sv/tci_datapath.sv
// ----------------------------------------------------------------------------
// tci_datapath
// Limit ordering, step walk, cubic evaluation and trapezoid area with a
// saturating sum. Every register moves only on the operation it is given.
// ----------------------------------------------------------------------------
module tci_datapath #(
	parameter int FRAC_BITS = tci_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  tci_pkg::tci_cmd_t                  cmd,
	output tci_pkg::tci_stat_t                 stat,
	input  logic signed [tci_pkg::IN_W-1:0]    left_limit,
	input  logic signed [tci_pkg::IN_W-1:0]    right_limit,
	input  logic signed [tci_pkg::IN_W-1:0]    step_width,
	output logic signed [tci_pkg::OUT_W-1:0]   integral,
	output logic [tci_pkg::ST_W-1:0]           status
);

	localparam int IW = tci_pkg::IN_W;
	localparam int OW = tci_pkg::OUT_W;
	localparam int MW = tci_pkg::MUL_W;
	localparam int PW = 2*IW;
	localparam int CW = 3*IW;
	localparam int FW = (3*FRAC_BITS + 5 > 76) ? 3*FRAC_BITS + 5 : 76;
	localparam int AW = IW + OW + 2;
	localparam int RS = 3*FRAC_BITS - tci_pkg::OUT_FRAC;

	localparam logic signed [FW-1:0] F_HALF = (FW'(1) << RS) >> 1;
	localparam logic signed [FW-1:0] F_BIAS = (FW'(5) << (3*FRAC_BITS)) + F_HALF;
	localparam logic signed [FW-1:0] F_MAX  = {{(FW-OW+1){1'b0}}, {(OW-1){1'b1}}};
	localparam logic signed [FW-1:0] F_MIN  = {{(FW-OW+1){1'b1}}, {(OW-1){1'b0}}};
	localparam logic signed [AW-1:0] A_HALF = AW'(1) << FRAC_BITS;
	localparam logic signed [AW-1:0] A_MAX  = {{(AW-OW+1){1'b0}}, {(OW-1){1'b1}}};
	localparam logic signed [AW-1:0] A_MIN  = {{(AW-OW+1){1'b1}}, {(OW-1){1'b0}}};
	localparam logic signed [OW-1:0] S_MAX  = {1'b0, {(OW-1){1'b1}}};
	localparam logic signed [OW-1:0] S_MIN  = {1'b1, {(OW-1){1'b0}}};

	logic signed [IW-1:0] lo_q, hi_q, step_q, x_q, arg_q;
	logic                 neg_q;
	logic [IW-1:0]        w_q;
	logic signed [OW-1:0] yl_q, yr_q, sum_q, s_q, area_q;
	logic                 sat_q, sneg_q;
	logic [OW-1:0]        smag_q;
	logic [PW-1:0]        p2_q, p3lo_q;
	logic [CW-1:0]        p3_q;
	logic signed [FW-1:0] t_q, acc_q;
	logic [2*MW-1:0]      plo_q;
	logic [AW-1:0]        prod_q;
	logic signed [AW-1:0] sp_q;
	logic signed [OW-1:0] integral_q;
	logic [tci_pkg::ST_W-1:0] status_q;

	logic [IW-1:0]        arg_mag;
	logic signed [IW:0]   span, step_x, x_step, hi_x;
	logic [FW-1:0]        p2x3;
	logic signed [FW-1:0] acc_sh;
	logic signed [AW-1:0] a_rnd, a_sh;
	logic signed [OW:0]   sum_x;
	logic                 mul_en;
	logic [MW-1:0]        mul_a, mul_b;
	logic [2*MW-1:0]      mul_p;

	tci_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	assign arg_mag = arg_q[IW-1] ? IW'(-arg_q) : IW'(arg_q);
	assign span    = {hi_q[IW-1], hi_q} - {lo_q[IW-1], lo_q};
	assign step_x  = {step_q[IW-1], step_q};
	assign x_step  = {x_q[IW-1], x_q} + step_x;
	assign hi_x    = {hi_q[IW-1], hi_q};
	assign p2x3    = FW'({p2_q, 1'b0}) + FW'(p2_q);
	assign acc_sh  = acc_q >>> RS;
	assign a_rnd   = sp_q + A_HALF;
	assign a_sh    = a_rnd >>> (FRAC_BITS + 1);
	assign sum_x   = {sum_q[OW-1], sum_q} + {area_q[OW-1], area_q};

	always_comb begin
		stat.bad_step  = (step_q <= 0) || (step_x > span);
		stat.full_fits = (x_step <= hi_x);
		stat.part_left = (x_q < hi_q);
	end

	// multiplier operand select: the square, then the cube in two halves,
	// then width times the ordinate sum in two halves
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		unique case (cmd.op)
			tci_pkg::OP_F1: begin
				mul_en = 1'b1;
				mul_a  = MW'(arg_mag);
				mul_b  = MW'(arg_mag);
			end
			tci_pkg::OP_F2: begin
				mul_en = 1'b1;
				mul_a  = MW'(mul_p[IW-1:0]);
				mul_b  = MW'(arg_mag);
			end
			tci_pkg::OP_F3: begin
				mul_en = 1'b1;
				mul_a  = MW'(p2_q[PW-1:IW]);
				mul_b  = MW'(arg_mag);
			end
			tci_pkg::OP_A3: begin
				mul_en = 1'b1;
				mul_a  = MW'(w_q);
				mul_b  = smag_q[MW-1:0];
			end
			tci_pkg::OP_A4: begin
				mul_en = 1'b1;
				mul_a  = MW'(w_q);
				mul_b  = smag_q[OW-1:MW];
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			tci_pkg::OP_LOAD: begin
				step_q <= step_width;
				if (right_limit < left_limit) begin
					lo_q  <= right_limit;
					hi_q  <= left_limit;
					neg_q <= 1'b1;
				end else begin
					lo_q  <= left_limit;
					hi_q  <= right_limit;
					neg_q <= 1'b0;
				end
			end
			tci_pkg::OP_INIT: begin
				x_q   <= lo_q;
				arg_q <= lo_q;
				sum_q <= '0;
				sat_q <= 1'b0;
			end
			tci_pkg::OP_ADV_FULL: begin
				yl_q  <= yr_q;
				w_q   <= IW'(step_q);
				x_q   <= x_step[IW-1:0];
				arg_q <= x_step[IW-1:0];
			end
			tci_pkg::OP_ADV_PART: begin
				yl_q  <= yr_q;
				w_q   <= IW'(hi_q - x_q);
				x_q   <= hi_q;
				arg_q <= hi_q;
			end
			tci_pkg::OP_F2: begin
				p2_q <= mul_p[PW-1:0];
			end
			tci_pkg::OP_F3: begin
				p3lo_q <= mul_p[PW-1:0];
				t_q    <= F_BIAS - (p2x3 << FRAC_BITS);
			end
			tci_pkg::OP_F4: begin
				p3_q <= {mul_p[PW-1:0], {IW{1'b0}}} + CW'(p3lo_q);
			end
			tci_pkg::OP_F5: begin
				// odd power keeps the sign of x
				if (arg_q[IW-1]) begin
					acc_q <= t_q - FW'(p3_q);
				end else begin
					acc_q <= t_q + FW'(p3_q);
				end
			end
			tci_pkg::OP_F6: begin
				if (acc_sh > F_MAX) begin
					yr_q <= S_MAX;
				end else if (acc_sh < F_MIN) begin
					yr_q <= S_MIN;
				end else begin
					yr_q <= acc_sh[OW-1:0];
				end
			end
			tci_pkg::OP_A1: begin
				s_q <= yl_q + yr_q;
			end
			tci_pkg::OP_A2: begin
				sneg_q <= s_q[OW-1];
				smag_q <= s_q[OW-1] ? OW'(-s_q) : OW'(s_q);
			end
			tci_pkg::OP_A4: begin
				plo_q <= mul_p;
			end
			tci_pkg::OP_A5: begin
				prod_q <= AW'({mul_p, {MW{1'b0}}}) + AW'(plo_q);
			end
			tci_pkg::OP_A6: begin
				sp_q <= sneg_q ? -prod_q : prod_q;
			end
			tci_pkg::OP_A7: begin
				if (a_sh > A_MAX) begin
					area_q <= S_MAX;
					sat_q  <= 1'b1;
				end else if (a_sh < A_MIN) begin
					area_q <= S_MIN;
					sat_q  <= 1'b1;
				end else begin
					area_q <= a_sh[OW-1:0];
				end
			end
			tci_pkg::OP_A8: begin
				if (sum_x[OW] != sum_x[OW-1]) begin
					sum_q <= sum_x[OW] ? S_MIN : S_MAX;
					sat_q <= 1'b1;
				end else begin
					sum_q <= sum_x[OW-1:0];
				end
			end
			tci_pkg::OP_FIN: begin
				if (neg_q && (sum_q == S_MIN)) begin
					integral_q <= S_MAX;
					status_q   <= tci_pkg::ST_SAT;
				end else begin
					integral_q <= neg_q ? -sum_q : sum_q;
					status_q   <= sat_q ? tci_pkg::ST_SAT : tci_pkg::ST_OK;
				end
			end
			tci_pkg::OP_BAD: begin
				integral_q <= '0;
				status_q   <= tci_pkg::ST_BAD_STEP;
			end
			default: begin
			end
		endcase
	end

	assign integral = integral_q;
	assign status   = status_q;

endmodule

// File: sv/tci_ctrl.sv
// ----------------------------------------------------------------------------
// tci_ctrl
// Sequencer for one integration: check, first ordinate, then per trapezoid
// an advance, the cubic evaluation (F1 to F6) and the area update (A1 to A8).
// ----------------------------------------------------------------------------
module tci_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  tci_pkg::tci_stat_t  stat,
	output tci_pkg::tci_cmd_t   cmd
);

	localparam int SW = 5;
	localparam logic [SW-1:0] S_IDLE   = 5'd0;
	localparam logic [SW-1:0] S_CHECK  = 5'd1;
	localparam logic [SW-1:0] S_F1     = 5'd2;
	localparam logic [SW-1:0] S_F2     = 5'd3;
	localparam logic [SW-1:0] S_F3     = 5'd4;
	localparam logic [SW-1:0] S_F4     = 5'd5;
	localparam logic [SW-1:0] S_F5     = 5'd6;
	localparam logic [SW-1:0] S_F6     = 5'd7;
	localparam logic [SW-1:0] S_DECIDE = 5'd8;
	localparam logic [SW-1:0] S_A1     = 5'd9;
	localparam logic [SW-1:0] S_A2     = 5'd10;
	localparam logic [SW-1:0] S_A3     = 5'd11;
	localparam logic [SW-1:0] S_A4     = 5'd12;
	localparam logic [SW-1:0] S_A5     = 5'd13;
	localparam logic [SW-1:0] S_A6     = 5'd14;
	localparam logic [SW-1:0] S_A7     = 5'd15;
	localparam logic [SW-1:0] S_A8     = 5'd16;
	localparam logic [SW-1:0] S_FIN    = 5'd17;
	localparam logic [SW-1:0] S_BAD    = 5'd18;

	logic [SW-1:0]               state_q, state_d;
	logic                        first_q, first_d;
	logic                        out_valid_q;
	logic                        slot_free;
	logic [tci_pkg::OP_W-1:0]    op;

	// output register may be refilled when empty or drained this cycle
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		first_d = first_q;
		op      = tci_pkg::OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = tci_pkg::OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.bad_step) begin
					state_d = S_BAD;
				end else begin
					op      = tci_pkg::OP_INIT;
					first_d = 1'b1;
					state_d = S_F1;
				end
			end
			S_F1: begin op = tci_pkg::OP_F1; state_d = S_F2; end
			S_F2: begin op = tci_pkg::OP_F2; state_d = S_F3; end
			S_F3: begin op = tci_pkg::OP_F3; state_d = S_F4; end
			S_F4: begin op = tci_pkg::OP_F4; state_d = S_F5; end
			S_F5: begin op = tci_pkg::OP_F5; state_d = S_F6; end
			S_F6: begin
				op      = tci_pkg::OP_F6;
				first_d = 1'b0;
				state_d = first_q ? S_DECIDE : S_A1;
			end
			S_DECIDE: begin
				if (stat.full_fits) begin
					op      = tci_pkg::OP_ADV_FULL;
					state_d = S_F1;
				end else if (stat.part_left) begin
					op      = tci_pkg::OP_ADV_PART;
					state_d = S_F1;
				end else begin
					state_d = S_FIN;
				end
			end
			S_A1: begin op = tci_pkg::OP_A1; state_d = S_A2; end
			S_A2: begin op = tci_pkg::OP_A2; state_d = S_A3; end
			S_A3: begin op = tci_pkg::OP_A3; state_d = S_A4; end
			S_A4: begin op = tci_pkg::OP_A4; state_d = S_A5; end
			S_A5: begin op = tci_pkg::OP_A5; state_d = S_A6; end
			S_A6: begin op = tci_pkg::OP_A6; state_d = S_A7; end
			S_A7: begin op = tci_pkg::OP_A7; state_d = S_A8; end
			S_A8: begin op = tci_pkg::OP_A8; state_d = S_DECIDE; end
			S_FIN: begin
				if (slot_free) begin
					op      = tci_pkg::OP_FIN;
					state_d = S_IDLE;
				end
			end
			S_BAD: begin
				if (slot_free) begin
					op      = tci_pkg::OP_BAD;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
			if ((op == tci_pkg::OP_FIN) || (op == tci_pkg::OP_BAD)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd.op = op;
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: sv/tci_checker.sv
// ----------------------------------------------------------------------------
// tci_checker
// Port-level checks on the integrator, bound to the top level.
// ----------------------------------------------------------------------------
module tci_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [tci_pkg::OUT_W-1:0]   integral,
	input logic [tci_pkg::ST_W-1:0]           status
);

	// an accepted beat keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(integral) && $stable(status))
		else $error("stalled result changed");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == tci_pkg::ST_BAD_STEP) |-> (integral == '0))
		else $error("rejected step with nonzero integral");

	// a new result only appears at the end of a busy stretch
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

endmodule

bind trapezoid_cubic_integrator_unit tci_checker u_tci_checker (.*);
